// ----- rtl/roe_pkg.sv -----
`timescale 1ns / 1ps
package roe_pkg;

  // default field formats
  localparam int unsigned COORD_BITS_DEF      = 20;
  localparam int unsigned COORD_FRAC_BITS_DEF = 8;
  localparam int unsigned UNIT_FRAC_BITS_DEF  = 14;

  // unit vector components are always 16 bits
  localparam int unsigned UNIT_BITS = 16;

  // slab interval start, +/- T_LIMIT_INT in whole units
  localparam int unsigned T_LIMIT_INT  = 999999;
  localparam int unsigned T_LIMIT_BITS = 20;

  // the entry offset product wraps at this width
  localparam int unsigned WRAP_BITS = 64;

  typedef enum logic [1:0] {
    MISS_NONE   = 2'd0,
    MISS_SLAB   = 2'd1,
    MISS_CROSS  = 2'd2,
    MISS_LENGTH = 2'd3
  } miss_e;

  function automatic int unsigned max_u(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/roe_if.sv -----
`timescale 1ns / 1ps
// ray and box beat
interface roe_in_if #(
  parameter int unsigned COORD_BITS = roe_pkg::COORD_BITS_DEF
);
  import roe_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [3*COORD_BITS-1:0]     ray_origin;
  logic [3*UNIT_BITS-1:0]      ray_dir;
  logic [COORD_BITS-1:0]       ray_length;
  logic [3*COORD_BITS-1:0]     box_center;
  logic [3*UNIT_BITS-1:0]      box_axis_x;
  logic [3*UNIT_BITS-1:0]      box_axis_y;
  logic [3*UNIT_BITS-1:0]      box_axis_z;
  logic [3*COORD_BITS-1:0]     box_half_sizes;

  modport source (
    output valid, ray_origin, ray_dir, ray_length, box_center,
           box_axis_x, box_axis_y, box_axis_z, box_half_sizes,
    input  ready
  );
  modport sink (
    input  valid, ray_origin, ray_dir, ray_length, box_center,
           box_axis_x, box_axis_y, box_axis_z, box_half_sizes,
    output ready
  );
endinterface

// test result beat
interface roe_out_if #(
  parameter int unsigned COORD_BITS = roe_pkg::COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [1:0]              miss_reason;
  logic [3*COORD_BITS-1:0] hit_point;

  modport source (
    output valid, hit, miss_reason, hit_point,
    input  ready
  );
  modport sink (
    input  valid, hit, miss_reason, hit_point,
    output ready
  );
endinterface

// ----- rtl/roe_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, sign applied last
module roe_div #(
  parameter int unsigned DW  = 53,
  parameter int unsigned DVW = 33
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [DW-1:0]         num_i,
  input  logic [DVW-1:0]        den_i,
  input  logic                  neg_i,
  output logic signed [DW:0]    quo_o
);

  logic [DVW-1:0] rem_q [DW];
  logic [DW-1:0]  dq_q  [DW];
  logic [DVW-1:0] den_q [DW];
  logic           neg_q [DW];
  logic signed [DW:0] quo_q;

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DVW-1:0] rem_in;
    logic [DW-1:0]  dq_in;
    logic [DVW-1:0] den_in;
    logic           neg_in;
    logic [DVW:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_in, dq_in[DW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DVW'(trial - {1'b0, den_in}) : trial[DVW-1:0];
        dq_q[k]  <= {dq_in[DW-2:0], ge};
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  // apply the quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[DW-1] ? -$signed({1'b0, dq_q[DW-1]}) : $signed({1'b0, dq_q[DW-1]});
    end
  end

  assign quo_o = quo_q;

endmodule

// ----- rtl/ray_obb_intersect.sv -----
`timescale 1ns / 1ps
// DW is the divider quotient width, with one pipelined divider stage per quotient bit
// throughput: one test per cycle while the skid entry is empty
// the six slab divisions run in six parallel dividers
// a two-entry output register keeps input open while one result waits
// reset: asynchronous, active low, clears all valid bits; no other state
module ray_obb_intersect #(
  parameter int unsigned COORD_BITS      = roe_pkg::COORD_BITS_DEF,
  parameter int unsigned COORD_FRAC_BITS = roe_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned UNIT_FRAC_BITS  = roe_pkg::UNIT_FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  roe_in_if.sink     in_i,
  roe_out_if.source  out_o
);
  import roe_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned UB   = UNIT_BITS;
  localparam int unsigned U    = UNIT_FRAC_BITS;
  localparam int unsigned RW   = CB + 1;
  localparam int unsigned FW   = 2 * UB + 2;
  localparam int unsigned DVW  = FW - 1;
  localparam int unsigned SW   = UB + RW + 2;
  localparam int unsigned NW   = max_u(SW, CB + U + 1) + 1;
  localparam int unsigned DW   = NW - 1 + U;
  localparam int unsigned TW   = max_u(DW + 1, T_LIMIT_BITS + COORD_FRAC_BITS + 1);
  localparam int unsigned XW   = UB + RW + 1;
  localparam int unsigned CLW  = XW + UB + 2;
  localparam int unsigned CRW  = CB + DVW + 1;
  localparam int unsigned CMW  = max_u(CLW, CRW);
  localparam int unsigned LB   = TW / 2;
  localparam int unsigned HB   = TW - LB;
  localparam int unsigned PLW  = UB + LB + 1;
  localparam int unsigned PHW  = UB + HB;
  localparam int unsigned PW   = UB + TW;
  localparam int unsigned MW   = max_u(PW, WRAP_BITS);
  localparam int unsigned OFW  = WRAP_BITS - U;
  localparam int unsigned PTW  = OFW + 1;
  localparam int unsigned SQW  = 2 * CB + 2;
  localparam int unsigned DLAT = DW + 1;
  localparam int unsigned DLY  = DLAT - 2;

  localparam logic signed [TW-1:0] T_HI =
    TW'(longint'(T_LIMIT_INT) << COORD_FRAC_BITS);
  localparam logic signed [TW-1:0] T_LO = -T_HI;
  localparam logic signed [PTW-1:0] P_HI = PTW'((longint'(1) << (CB - 1)) - 1);
  localparam logic signed [PTW-1:0] P_LO = -PTW'(longint'(1) << (CB - 1));

  typedef struct packed {
    logic [2:0]          pm;
    logic [2:0]          fz;
    logic                cx;
    logic [2:0][CB-1:0]  o;
    logic [2:0][UB-1:0]  d;
    logic [CB-1:0]       len;
  } side_t;

  typedef struct packed {
    logic signed [TW-1:0] tmin;
    logic signed [TW-1:0] tmax;
    miss_e                reason;
    logic [2:0][TW-1:0]   q1;
    logic [2:0][TW-1:0]   q2;
    side_t                sd;
  } slab_t;

  // one slab axis: narrow the interval, flag an empty or outside slab
  function automatic slab_t slab_step(slab_t a, int unsigned v);
    slab_t                b;
    logic signed [TW-1:0] q1;
    logic signed [TW-1:0] q2;
    logic signed [TW-1:0] lo;
    logic signed [TW-1:0] hi;
    logic signed [TW-1:0] nmin;
    logic signed [TW-1:0] nmax;
    b    = a;
    q1   = $signed(a.q1[v]);
    q2   = $signed(a.q2[v]);
    lo   = (q1 > q2) ? q2 : q1;
    hi   = (q1 > q2) ? q1 : q2;
    nmin = (lo > a.tmin) ? lo : a.tmin;
    nmax = (hi < a.tmax) ? hi : a.tmax;
    if (a.reason == MISS_NONE) begin
      if (a.sd.pm[v]) begin
        b.reason = MISS_SLAB;
      end else if (!a.sd.fz[v]) begin
        b.tmin = nmin;
        b.tmax = nmax;
        if (nmin > nmax) begin
          b.reason = MISS_SLAB;
        end
      end
    end
    return b;
  endfunction

  logic en;

  // ---------------------------------------------------------------- stage 1
  logic                 v1_q;
  logic signed [CB-1:0] s1_o_q  [3];
  logic signed [RW-1:0] s1_r_q  [3];
  logic signed [UB-1:0] s1_d_q  [3];
  logic signed [UB-1:0] s1_ax_q [3][3];
  logic [CB-1:0]        s1_e_q  [3];
  logic [CB-1:0]        s1_len_q;

  // unpack the beat and form origin minus center
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_o_q[i]     <= $signed(in_i.ray_origin[i*CB +: CB]);
        s1_r_q[i]     <= RW'($signed(in_i.ray_origin[i*CB +: CB]))
                       - RW'($signed(in_i.box_center[i*CB +: CB]));
        s1_d_q[i]     <= $signed(in_i.ray_dir[i*UB +: UB]);
        s1_ax_q[0][i] <= $signed(in_i.box_axis_x[i*UB +: UB]);
        s1_ax_q[1][i] <= $signed(in_i.box_axis_y[i*UB +: UB]);
        s1_ax_q[2][i] <= $signed(in_i.box_axis_z[i*UB +: UB]);
        s1_e_q[i]     <= in_i.box_half_sizes[i*CB +: CB];
      end
      s1_len_q <= in_i.ray_length;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                      v2_q;
  logic signed [2*UB-1:0]    s2_af_q [3][3];
  logic signed [UB+RW-1:0]   s2_as_q [3][3];
  logic signed [UB+RW-1:0]   s2_cpa_q [3];
  logic signed [UB+RW-1:0]   s2_cpb_q [3];
  logic signed [CB-1:0]      s2_o_q  [3];
  logic signed [UB-1:0]      s2_d_q  [3];
  logic signed [UB-1:0]      s2_ax_q [3][3];
  logic [CB-1:0]             s2_e_q  [3];
  logic [CB-1:0]             s2_len_q;

  // axis products with direction and offset, cross product terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int j = 0; j < 3; j++) begin
          s2_af_q[v][j] <= (2*UB)'(s1_ax_q[v][j]) * (2*UB)'(s1_d_q[j]);
          s2_as_q[v][j] <= (UB+RW)'(s1_ax_q[v][j]) * (UB+RW)'(s1_r_q[j]);
        end
      end
      s2_cpa_q[0] <= (UB+RW)'(s1_d_q[1]) * (UB+RW)'(s1_r_q[2]);
      s2_cpb_q[0] <= (UB+RW)'(s1_d_q[2]) * (UB+RW)'(s1_r_q[1]);
      s2_cpa_q[1] <= (UB+RW)'(s1_d_q[2]) * (UB+RW)'(s1_r_q[0]);
      s2_cpb_q[1] <= (UB+RW)'(s1_d_q[0]) * (UB+RW)'(s1_r_q[2]);
      s2_cpa_q[2] <= (UB+RW)'(s1_d_q[0]) * (UB+RW)'(s1_r_q[1]);
      s2_cpb_q[2] <= (UB+RW)'(s1_d_q[1]) * (UB+RW)'(s1_r_q[0]);
      s2_o_q   <= s1_o_q;
      s2_d_q   <= s1_d_q;
      s2_ax_q  <= s1_ax_q;
      s2_e_q   <= s1_e_q;
      s2_len_q <= s1_len_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                  v3_q;
  logic signed [FW-1:0]  s3_f_q   [3];
  logic signed [SW-1:0]  s3_s_q   [3];
  logic signed [XW-1:0]  s3_dxr_q [3];
  logic signed [CB-1:0]  s3_o_q   [3];
  logic signed [UB-1:0]  s3_d_q   [3];
  logic signed [UB-1:0]  s3_ax_q  [3][3];
  logic [CB-1:0]         s3_e_q   [3];
  logic [CB-1:0]         s3_len_q;

  // dot products and the direction cross offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        s3_f_q[v]   <= FW'(s2_af_q[v][0]) + FW'(s2_af_q[v][1]) + FW'(s2_af_q[v][2]);
        s3_s_q[v]   <= SW'(s2_as_q[v][0]) + SW'(s2_as_q[v][1]) + SW'(s2_as_q[v][2]);
        s3_dxr_q[v] <= XW'(s2_cpa_q[v]) - XW'(s2_cpb_q[v]);
      end
      s3_o_q   <= s2_o_q;
      s3_d_q   <= s2_d_q;
      s3_ax_q  <= s2_ax_q;
      s3_e_q   <= s2_e_q;
      s3_len_q <= s2_len_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic                    v4_q;
  logic signed [NW-1:0]    s4_n1_q [3];
  logic signed [NW-1:0]    s4_n2_q [3];
  logic [2:0]              s4_pm_q;
  logic [2:0]              s4_fz_q;
  logic [2:0]              s4_fneg_q;
  logic [DVW-1:0]          s4_fa_q [3];
  logic signed [XW+UB-1:0] s4_xp_q [3][3];
  logic signed [CB-1:0]    s4_o_q  [3];
  logic signed [UB-1:0]    s4_d_q  [3];
  logic [CB-1:0]           s4_e_q  [3];
  logic [CB-1:0]           s4_len_q;

  logic signed [NW-1:0] s4_eu  [3];
  logic signed [NW-1:0] s4_sx  [3];
  logic [NW-1:0]        s4_sa  [3];
  logic [2:0]           s4_pm_d;

  // slab numerators and the outside-slab check
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      s4_eu[v]   = $signed(NW'({s3_e_q[v], U'(0)}));
      s4_sx[v]   = NW'(s3_s_q[v]);
      s4_sa[v]   = s4_sx[v][NW-1] ? NW'(-s4_sx[v]) : NW'(s4_sx[v]);
      s4_pm_d[v] = (s4_sa[v] > NW'(s4_eu[v]))
                && !((s3_s_q[v] > 0 && s3_f_q[v] < 0) || (s3_s_q[v] < 0 && s3_f_q[v] > 0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        s4_n1_q[v]   <= -s4_sx[v] - s4_eu[v];
        s4_n2_q[v]   <= -s4_sx[v] + s4_eu[v];
        s4_fz_q[v]   <= (s3_f_q[v] == '0);
        s4_fneg_q[v] <= s3_f_q[v][FW-1];
        s4_fa_q[v]   <= s3_f_q[v][FW-1] ? DVW'(-s3_f_q[v]) : DVW'(s3_f_q[v]);
        for (int j = 0; j < 3; j++) begin
          s4_xp_q[v][j] <= (XW+UB)'(s3_dxr_q[j]) * (XW+UB)'(s3_ax_q[v][j]);
        end
      end
      s4_pm_q  <= s4_pm_d;
      s4_o_q   <= s3_o_q;
      s4_d_q   <= s3_d_q;
      s4_e_q   <= s3_e_q;
      s4_len_q <= s3_len_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic                  v5_q;
  logic [DW-1:0]         s5_m1_q [3];
  logic [DW-1:0]         s5_m2_q [3];
  logic [2:0]            s5_neg1_q;
  logic [2:0]            s5_neg2_q;
  logic [DVW-1:0]        s5_fa_q [3];
  logic signed [CLW-1:0] s5_cl_q [3];
  logic [CB+DVW-1:0]     s5_ep_q [3][2];
  side_t                 s5_sd_q;

  logic [NW-1:0] s5_a1 [3];
  logic [NW-1:0] s5_a2 [3];
  side_t         s5_sd_d;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      s5_a1[v] = s4_n1_q[v][NW-1] ? NW'(-s4_n1_q[v]) : NW'(s4_n1_q[v]);
      s5_a2[v] = s4_n2_q[v][NW-1] ? NW'(-s4_n2_q[v]) : NW'(s4_n2_q[v]);
    end
    s5_sd_d.pm  = s4_pm_q;
    s5_sd_d.fz  = s4_fz_q;
    s5_sd_d.cx  = 1'b0;
    s5_sd_d.len = s4_len_q;
    for (int i = 0; i < 3; i++) begin
      s5_sd_d.o[i] = s4_o_q[i];
      s5_sd_d.d[i] = s4_d_q[i];
    end
  end

  // divider operands, cross-axis sums and extent products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        s5_m1_q[v]   <= {s5_a1[v][NW-2:0], U'(0)};
        s5_m2_q[v]   <= {s5_a2[v][NW-2:0], U'(0)};
        s5_neg1_q[v] <= s4_n1_q[v][NW-1] ^ s4_fneg_q[v];
        s5_neg2_q[v] <= s4_n2_q[v][NW-1] ^ s4_fneg_q[v];
        s5_cl_q[v]   <= CLW'(s4_xp_q[v][0]) + CLW'(s4_xp_q[v][1]) + CLW'(s4_xp_q[v][2]);
      end
      s5_fa_q       <= s4_fa_q;
      s5_ep_q[0][0] <= (CB+DVW)'(s4_e_q[1]) * (CB+DVW)'(s4_fa_q[2]);
      s5_ep_q[0][1] <= (CB+DVW)'(s4_e_q[2]) * (CB+DVW)'(s4_fa_q[1]);
      s5_ep_q[1][0] <= (CB+DVW)'(s4_e_q[0]) * (CB+DVW)'(s4_fa_q[2]);
      s5_ep_q[1][1] <= (CB+DVW)'(s4_e_q[2]) * (CB+DVW)'(s4_fa_q[0]);
      s5_ep_q[2][0] <= (CB+DVW)'(s4_e_q[0]) * (CB+DVW)'(s4_fa_q[1]);
      s5_ep_q[2][1] <= (CB+DVW)'(s4_e_q[1]) * (CB+DVW)'(s4_fa_q[0]);
      s5_sd_q       <= s5_sd_d;
    end
  end

  // slab divisions, both bounds of each axis
  logic signed [DW:0] q1 [3];
  logic signed [DW:0] q2 [3];

  for (genvar v = 0; v < 3; v++) begin : g_div
    roe_div #(.DW(DW), .DVW(DVW)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s5_m1_q[v]),
      .den_i (s5_fa_q[v]),
      .neg_i (s5_neg1_q[v]),
      .quo_o (q1[v])
    );
    roe_div #(.DW(DW), .DVW(DVW)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s5_m2_q[v]),
      .den_i (s5_fa_q[v]),
      .neg_i (s5_neg2_q[v]),
      .quo_o (q2[v])
    );
  end

  // ---------------------------------------------------------------- stage 6
  logic                  v6_q;
  logic [CRW-1:0]        s6_cr_q  [3];
  logic [CLW-1:0]        s6_acl_q [3];
  side_t                 s6_sd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        s6_cr_q[v]  <= CRW'(s5_ep_q[v][0]) + CRW'(s5_ep_q[v][1]);
        s6_acl_q[v] <= s5_cl_q[v][CLW-1] ? CLW'(-s5_cl_q[v]) : CLW'(s5_cl_q[v]);
      end
      s6_sd_q <= s5_sd_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic  v7_q;
  side_t s7_sd_q;
  side_t s7_sd_d;

  // cross-axis separation
  always_comb begin
    s7_sd_d    = s6_sd_q;
    s7_sd_d.cx = 1'b0;
    for (int v = 0; v < 3; v++) begin
      if (CMW'(s6_acl_q[v]) > CMW'(s6_cr_q[v])) begin
        s7_sd_d.cx = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_sd_q <= s7_sd_d;
    end
  end

  // side data waits for the dividers
  logic  dlv_q [DLY];
  side_t dl_q  [DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= s7_sd_q;
      for (int k = 1; k < DLY; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- slab merge
  logic  slv_q [3];
  slab_t sl_q  [3];
  slab_t sl_seed;
  slab_t sl_d  [3];

  always_comb begin
    sl_seed.tmin   = T_LO;
    sl_seed.tmax   = T_HI;
    sl_seed.reason = MISS_NONE;
    sl_seed.sd     = dl_q[DLY-1];
    for (int v = 0; v < 3; v++) begin
      sl_seed.q1[v] = TW'(q1[v]);
      sl_seed.q2[v] = TW'(q2[v]);
    end
    sl_d[0] = slab_step(sl_seed, 0);
    sl_d[1] = slab_step(sl_q[0], 1);
    sl_d[2] = slab_step(sl_q[1], 2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_q <= sl_d;
    end
  end

  // ---------------------------------------------------------------- offset m1
  logic                  m1v_q;
  logic signed [PLW-1:0] m1_plo_q [3];
  logic signed [PHW-1:0] m1_phi_q [3];
  logic signed [CB-1:0]  m1_o_q   [3];
  logic [CB-1:0]         m1_len_q;
  miss_e                 m1_reason_q;
  miss_e                 m1_reason_d;

  logic signed [LB:0]    m1_tlo;
  logic signed [HB-1:0]  m1_thi;

  always_comb begin
    m1_reason_d = sl_q[2].reason;
    if (sl_q[2].reason == MISS_NONE && sl_q[2].sd.cx) begin
      m1_reason_d = MISS_CROSS;
    end
    m1_tlo = $signed({1'b0, sl_q[2].tmin[LB-1:0]});
    m1_thi = $signed(sl_q[2].tmin[TW-1:LB]);
  end

  // direction times t_min in two partial products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_plo_q[i] <= PLW'($signed(sl_q[2].sd.d[i])) * PLW'(m1_tlo);
        m1_phi_q[i] <= PHW'($signed(sl_q[2].sd.d[i])) * PHW'(m1_thi);
        m1_o_q[i]   <= $signed(sl_q[2].sd.o[i]);
      end
      m1_len_q    <= sl_q[2].sd.len;
      m1_reason_q <= m1_reason_d;
    end
  end

  // ---------------------------------------------------------------- offset m2
  logic                  m2v_q;
  logic signed [OFW-1:0] m2_off_q [3];
  logic signed [CB-1:0]  m2_o_q   [3];
  logic [CB-1:0]         m2_len_q;
  miss_e                 m2_reason_q;

  logic signed [MW-1:0]  m2_full [3];

  // join partial products, wrap, floor shift to coordinate format
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_full[i] = (MW'(m1_phi_q[i]) <<< LB) + MW'(m1_plo_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m2_off_q[i] <= $signed(m2_full[i][WRAP_BITS-1:U]);
      end
      m2_o_q      <= m1_o_q;
      m2_len_q    <= m1_len_q;
      m2_reason_q <= m1_reason_q;
    end
  end

  // ---------------------------------------------------------------- length m3
  logic                 m3v_q;
  logic [CB-1:0]        m3_sqin_q [3];
  logic [CB-1:0]        m3_pt_q   [3];
  logic [CB-1:0]        m3_len_q;
  miss_e                m3_reason_q;

  logic [OFW-1:0]       m3_aoff [3];
  logic signed [PTW-1:0] m3_p   [3];
  logic [CB-1:0]        m3_pt   [3];
  logic                 m3_big;
  miss_e                m3_reason_d;

  // per-axis bound and saturated entry point
  always_comb begin
    m3_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m3_aoff[i] = m2_off_q[i][OFW-1] ? OFW'(-m2_off_q[i]) : OFW'(m2_off_q[i]);
      if (m3_aoff[i] > OFW'(m2_len_q)) begin
        m3_big = 1'b1;
      end
      m3_p[i] = PTW'(m2_o_q[i]) + PTW'(m2_off_q[i]);
      if (m3_p[i] < P_LO) begin
        m3_pt[i] = P_LO[CB-1:0];
      end else if (m3_p[i] > P_HI) begin
        m3_pt[i] = P_HI[CB-1:0];
      end else begin
        m3_pt[i] = m3_p[i][CB-1:0];
      end
    end
    m3_reason_d = m2_reason_q;
    if (m2_reason_q == MISS_NONE && m3_big) begin
      m3_reason_d = MISS_LENGTH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m3_sqin_q[i] <= m3_aoff[i][CB-1:0];
      end
      m3_pt_q     <= m3_pt;
      m3_len_q    <= m2_len_q;
      m3_reason_q <= m3_reason_d;
    end
  end

  // ---------------------------------------------------------------- length m4
  logic              m4v_q;
  logic [2*CB-1:0]   m4_sq_q [3];
  logic [2*CB-1:0]   m4_lsq_q;
  logic [CB-1:0]     m4_pt_q [3];
  miss_e             m4_reason_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m4_sq_q[i] <= (2*CB)'(m3_sqin_q[i]) * (2*CB)'(m3_sqin_q[i]);
      end
      m4_lsq_q    <= (2*CB)'(m3_len_q) * (2*CB)'(m3_len_q);
      m4_pt_q     <= m3_pt_q;
      m4_reason_q <= m3_reason_q;
    end
  end

  // final distance compare and result
  logic [SQW-1:0]     fin_sum;
  miss_e              fin_reason;
  logic               fin_hit;
  logic [3*CB-1:0]    fin_point;

  always_comb begin
    fin_sum    = SQW'(m4_sq_q[0]) + SQW'(m4_sq_q[1]) + SQW'(m4_sq_q[2]);
    fin_reason = m4_reason_q;
    if (m4_reason_q == MISS_NONE && fin_sum > SQW'(m4_lsq_q)) begin
      fin_reason = MISS_LENGTH;
    end
    fin_hit   = (fin_reason == MISS_NONE);
    fin_point = '0;
    if (fin_hit) begin
      for (int i = 0; i < 3; i++) begin
        fin_point[i*CB +: CB] = m4_pt_q[i];
      end
    end
  end

  // ---------------------------------------------------------------- output and skid
  logic            ov_q;
  logic            ohit_q;
  miss_e           oreason_q;
  logic [3*CB-1:0] opoint_q;
  logic            sv_q;
  logic            shit_q;
  miss_e           sreason_q;
  logic [3*CB-1:0] spoint_q;
  logic            pop;

  assign pop = ov_q && out_o.ready;
  assign en  = !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) begin
        sv_q <= 1'b0;
      end
    end else if (m4v_q) begin
      if (ov_q && !pop) begin
        sv_q <= 1'b1;
      end else begin
        ov_q <= 1'b1;
      end
    end else if (pop) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) begin
        ohit_q    <= shit_q;
        oreason_q <= sreason_q;
        opoint_q  <= spoint_q;
      end
    end else if (m4v_q) begin
      if (ov_q && !pop) begin
        shit_q    <= fin_hit;
        sreason_q <= fin_reason;
        spoint_q  <= fin_point;
      end else begin
        ohit_q    <= fin_hit;
        oreason_q <= fin_reason;
        opoint_q  <= fin_point;
      end
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      for (int k = 0; k < DLY; k++) begin
        dlv_q[k] <= 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
        slv_q[k] <= 1'b0;
      end
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
      m3v_q <= 1'b0;
      m4v_q <= 1'b0;
    end else if (en) begin
      v1_q     <= in_i.valid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      v7_q     <= v6_q;
      dlv_q[0] <= v7_q;
      for (int k = 1; k < DLY; k++) begin
        dlv_q[k] <= dlv_q[k-1];
      end
      slv_q[0] <= dlv_q[DLY-1];
      slv_q[1] <= slv_q[0];
      slv_q[2] <= slv_q[1];
      m1v_q    <= slv_q[2];
      m2v_q    <= m1v_q;
      m3v_q    <= m2v_q;
      m4v_q    <= m3v_q;
    end
  end

  // ports
  assign in_i.ready        = en;
  assign out_o.valid       = ov_q;
  assign out_o.hit         = ohit_q;
  assign out_o.miss_reason = oreason_q;
  assign out_o.hit_point   = opoint_q;

endmodule

// ----- rtl/roe_chk.sv -----
`timescale 1ns / 1ps
// port-level checks on the result channel
module roe_chk #(
  parameter int unsigned COORD_BITS = roe_pkg::COORD_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    hit_i,
  input logic [1:0]              miss_reason_i,
  input logic [3*COORD_BITS-1:0] hit_point_i
);
  import roe_pkg::*;

  // a result beat stays until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before accept");

  // a waiting result beat does not change
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(hit_i) && $stable(miss_reason_i) && $stable(hit_point_i))
    else $error("result beat changed while stalled");

  // hit flag agrees with the miss code
  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (hit_i == (miss_reason_i == MISS_NONE)))
    else $error("hit flag and miss reason disagree");

  // a miss carries no point
  a_miss_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> (hit_point_i == '0))
    else $error("miss result with nonzero point");

endmodule

bind ray_obb_intersect roe_chk #(.COORD_BITS(COORD_BITS)) u_roe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .hit_i         (out_o.hit),
  .miss_reason_i (out_o.miss_reason),
  .hit_point_i   (out_o.hit_point)
);
